// File: rtl/core/bsc_pkg.sv
// Package for the barometric sensor compensation unit: widths, register
// indexes, reset values, formula constants and small arithmetic helpers.
// No dependencies.
package bsc_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;

   typedef enum logic [IDX_W-1:0] {
      CSR_AC1_AC2 = 3'd0,
      CSR_AC3_AC4 = 3'd1,
      CSR_AC5_AC6 = 3'd2,
      CSR_B1_B2   = 3'd3,
      CSR_MC_MD   = 3'd4,
      CSR_OSS     = 3'd5
   } csr_idx_type;

   localparam logic [31:0] RST_AC1_AC2 = 32'h0198_FFB8;
   localparam logic [31:0] RST_AC3_AC4 = 32'hC7D1_7FE5;
   localparam logic [31:0] RST_AC5_AC6 = 32'h7FF5_5A71;
   localparam logic [31:0] RST_B1_B2   = 32'h182E_0004;
   localparam logic [31:0] RST_MC_MD   = 32'hDDF9_0B34;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] PRES_SCALE  = 32'd50000;
   localparam logic [31:0] K_SQ        = 32'd3038;
   localparam logic [31:0] K_LIN       = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] K_OFS       = 32'd3791;
   localparam logic [31:0] B4_OFFSET   = 32'd32768;

   // Carried beside the temperature divider.
   typedef struct packed {
      logic        func;
      logic [18:0] up;
      logic [31:0] x1;
      logic        neg;
      logic        zero;
   } d1_side_type;

   // Per-item context after the temperature path is done.
   typedef struct packed {
      logic        func;
      logic        err;
      logic [31:0] tval;
   } ctx_type;

   // Carried beside the pressure divider.
   typedef struct packed {
      ctx_type ctx;
      logic    post_shl;
   } d2_side_type;

   function automatic logic [31:0] sx16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
      return 32'($signed(x) >>> n);
   endfunction

endpackage

// File: rtl/core/bsc_div_pipe.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bsc_pkg.
module bsc_div_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [31:0]       in_dvd,
   input  logic [31:0]       in_dvs,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [31:0]       out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = bsc_pkg::DATA_W;

   logic              vld_ff  [STAGES];
   logic [31:0]       rem_ff  [STAGES];
   logic [31:0]       dvd_ff  [STAGES];
   logic [31:0]       dvs_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic              p_vld;
      logic [31:0]       p_rem, p_dvd, p_dvs;
      logic [SIDE_W-1:0] p_side;
      logic [32:0]       trial;
      logic              take;
      logic [31:0]       rem_in, dvd_in;

      if (g == 0) begin : g_first
         assign p_vld  = in_vld;
         assign p_rem  = '0;
         assign p_dvd  = in_dvd;
         assign p_dvs  = in_dvs;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[g-1];
         assign p_rem  = rem_ff[g-1];
         assign p_dvd  = dvd_ff[g-1];
         assign p_dvs  = dvs_ff[g-1];
         assign p_side = side_ff[g-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial  = {p_rem, p_dvd[31]};
      assign take   = trial >= {1'b0, p_dvs};
      assign rem_in = take ? 32'(trial - {1'b0, p_dvs}) : trial[31:0];
      assign dvd_in = {p_dvd[30:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            dvd_ff[g]  <= dvd_in;
            dvs_ff[g]  <= p_dvs;
            side_ff[g] <= p_side;
         end
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = dvd_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

// File: rtl/core/barometric_sensor_compensation_unit.sv
// Barometric sensor compensation: raw temperature/pressure counts to 0.1 C or Pa.
// 75 register stages from req transfer to rsp_valid; throughput one item per cycle while rsp is
// not stalled. The two 32-stage divider pipelines (temperature B5 quotient, pressure quotient)
// set depth. Whole pipeline advances together; a stalled rsp holds every stage.
// Synchronous active-high reset clears valid bits and loads calibration defaults.
// Depends on bsc_pkg and bsc_div_pipe.
module barometric_sensor_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_raw_temp,
   input  logic [18:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic        rsp_div_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // ---------------------------------------------------------------------
   // Calibration registers
   // ---------------------------------------------------------------------
   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= bsc_pkg::RST_AC1_AC2;
         ac3_ac4_ff <= bsc_pkg::RST_AC3_AC4;
         ac5_ac6_ff <= bsc_pkg::RST_AC5_AC6;
         b1_b2_ff   <= bsc_pkg::RST_B1_B2;
         mc_md_ff   <= bsc_pkg::RST_MC_MD;
         oss_ff     <= '0;
      end else if (csr_valid) begin
         // indexes past the list are dropped
         unique case (csr_index)
            bsc_pkg::CSR_AC1_AC2: ac1_ac2_ff <= csr_data;
            bsc_pkg::CSR_AC3_AC4: ac3_ac4_ff <= csr_data;
            bsc_pkg::CSR_AC5_AC6: ac5_ac6_ff <= csr_data;
            bsc_pkg::CSR_B1_B2:   b1_b2_ff   <= csr_data;
            bsc_pkg::CSR_MC_MD:   mc_md_ff   <= csr_data;
            bsc_pkg::CSR_OSS:     oss_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // unpacked coefficients, 32-bit sign or zero extended
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = bsc_pkg::sx16(ac1_ac2_ff[31:16]);
   assign ac2 = bsc_pkg::sx16(ac1_ac2_ff[15:0]);
   assign ac3 = bsc_pkg::sx16(ac3_ac4_ff[31:16]);
   assign ac4 = {16'd0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5_ac6_ff[15:0]};
   assign b1  = bsc_pkg::sx16(b1_b2_ff[31:16]);
   assign b2  = bsc_pkg::sx16(b1_b2_ff[15:0]);
   assign mc  = bsc_pkg::sx16(mc_md_ff[31:16]);
   assign md  = bsc_pkg::sx16(mc_md_ff[15:0]);

   // ---------------------------------------------------------------------
   // Global advance: every stage moves when the output slot is free or taken
   // ---------------------------------------------------------------------
   logic adv;
   logic rsp_vld_ff;

   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------------
   // S1: (UT - AC6) * AC5
   // ---------------------------------------------------------------------
   logic        s1_vld_ff;
   logic        s1_func_ff;
   logic [18:0] s1_up_ff;
   logic [31:0] s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff <= req_func;
         s1_up_ff   <= req_raw_pressure;
         s1_prod_ff <= ({16'd0, req_raw_temp} - ac6) * ac5;
      end
   end

   // ---------------------------------------------------------------------
   // S2: X1, divisor X1 + MD, sign/magnitude split of MC << 11 / divisor
   // ---------------------------------------------------------------------
   logic              s2_vld_ff;
   logic [31:0]       s2_ma_ff, s2_mb_ff;
   bsc_pkg::d1_side_type s2_side_ff;

   logic [31:0] x1_t, den_t, num_t;
   assign x1_t  = bsc_pkg::asr32(s1_prod_ff, 5'd15);
   assign den_t = x1_t + md;
   assign num_t = mc << 11;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ma_ff        <= num_t[31] ? 32'(-num_t) : num_t;
         s2_mb_ff        <= den_t[31] ? 32'(-den_t) : den_t;
         s2_side_ff.func <= s1_func_ff;
         s2_side_ff.up   <= s1_up_ff;
         s2_side_ff.x1   <= x1_t;
         s2_side_ff.neg  <= num_t[31] ^ den_t[31];
         s2_side_ff.zero <= (den_t == '0);
      end
   end

   // temperature quotient
   logic                 d1_vld;
   logic [31:0]          d1_quo;
   bsc_pkg::d1_side_type d1_side;

   bsc_div_pipe #(
      .SIDE_W ($bits(bsc_pkg::d1_side_type))
   ) u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s2_vld_ff),
      .in_dvd   (s2_ma_ff),
      .in_dvs   (s2_mb_ff),
      .in_side  (s2_side_ff),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // ---------------------------------------------------------------------
   // S3: B5, temperature result, B6
   // ---------------------------------------------------------------------
   logic             s3_vld_ff;
   bsc_pkg::ctx_type s3_ctx_ff;
   logic [18:0]      s3_up_ff;
   logic [31:0]      s3_b6_ff;

   logic [31:0] b5_t;
   assign b5_t = d1_side.x1 + (d1_side.neg ? 32'(-d1_quo) : d1_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= d1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ctx_ff.func <= d1_side.func;
         s3_ctx_ff.err  <= d1_side.zero;
         s3_ctx_ff.tval <= bsc_pkg::asr32(b5_t + 32'd8, 5'd4);
         s3_up_ff       <= d1_side.up;
         s3_b6_ff       <= b5_t - bsc_pkg::B6_OFFSET;
      end
   end

   // ---------------------------------------------------------------------
   // S4: B6*B6, AC2*B6, AC3*B6
   // ---------------------------------------------------------------------
   logic             s4_vld_ff;
   bsc_pkg::ctx_type s4_ctx_ff;
   logic [18:0]      s4_up_ff;
   logic [31:0]      s4_sq_ff, s4_ac2_ff, s4_ac3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ctx_ff <= s3_ctx_ff;
         s4_up_ff  <= s3_up_ff;
         s4_sq_ff  <= s3_b6_ff * s3_b6_ff;
         s4_ac2_ff <= ac2 * s3_b6_ff;
         s4_ac3_ff <= ac3 * s3_b6_ff;
      end
   end

   // ---------------------------------------------------------------------
   // S5: scale the products
   // ---------------------------------------------------------------------
   logic             s5_vld_ff;
   bsc_pkg::ctx_type s5_ctx_ff;
   logic [18:0]      s5_up_ff;
   logic [31:0]      s5_sq_ff, s5_x2a_ff, s5_x1c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ctx_ff <= s4_ctx_ff;
         s5_up_ff  <= s4_up_ff;
         s5_sq_ff  <= bsc_pkg::asr32(s4_sq_ff, 5'd12);
         s5_x2a_ff <= bsc_pkg::asr32(s4_ac2_ff, 5'd11);
         s5_x1c_ff <= bsc_pkg::asr32(s4_ac3_ff, 5'd13);
      end
   end

   // ---------------------------------------------------------------------
   // S6: B2*sq, B1*sq
   // ---------------------------------------------------------------------
   logic             s6_vld_ff;
   bsc_pkg::ctx_type s6_ctx_ff;
   logic [18:0]      s6_up_ff;
   logic [31:0]      s6_b2_ff, s6_b1_ff, s6_x2a_ff, s6_x1c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ctx_ff <= s5_ctx_ff;
         s6_up_ff  <= s5_up_ff;
         s6_b2_ff  <= b2 * s5_sq_ff;
         s6_b1_ff  <= b1 * s5_sq_ff;
         s6_x2a_ff <= s5_x2a_ff;
         s6_x1c_ff <= s5_x1c_ff;
      end
   end

   // ---------------------------------------------------------------------
   // S7: B3 and X3
   // ---------------------------------------------------------------------
   logic             s7_vld_ff;
   bsc_pkg::ctx_type s7_ctx_ff;
   logic [18:0]      s7_up_ff;
   logic [31:0]      s7_b3_ff, s7_x3_ff;

   logic [31:0] b3_sum, x3_sum;
   assign b3_sum = ((ac1 << 2) + bsc_pkg::asr32(s6_b2_ff, 5'd11) + s6_x2a_ff) << oss_ff;
   assign x3_sum = s6_x1c_ff + bsc_pkg::asr32(s6_b1_ff, 5'd16) + 32'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_ctx_ff <= s6_ctx_ff;
         s7_up_ff  <= s6_up_ff;
         s7_b3_ff  <= bsc_pkg::asr32(b3_sum + 32'd2, 5'd2);
         s7_x3_ff  <= bsc_pkg::asr32(x3_sum, 5'd2);
      end
   end

   // ---------------------------------------------------------------------
   // S8: B4 and B7
   // ---------------------------------------------------------------------
   logic             s8_vld_ff;
   bsc_pkg::ctx_type s8_ctx_ff;
   logic [31:0]      s8_b4_ff, s8_b7_ff;

   logic [31:0] b4_prod;
   assign b4_prod = ac4 * (s7_x3_ff + bsc_pkg::B4_OFFSET);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_ctx_ff <= s7_ctx_ff;
         s8_b4_ff  <= b4_prod >> 15;
         s8_b7_ff  <= ({13'd0, s7_up_ff} - s7_b3_ff) * (bsc_pkg::PRES_SCALE >> oss_ff);
      end
   end

   // Two-way quotient: pre-shift small B7, post-shift large B7.
   bsc_pkg::d2_side_type d2_in_side;
   logic [31:0]          d2_dvd;

   always_comb begin
      d2_in_side.ctx      = s8_ctx_ff;
      d2_in_side.ctx.err  = s8_ctx_ff.err || (s8_ctx_ff.func && (s8_b4_ff == '0));
      d2_in_side.post_shl = s8_b7_ff[31];
      d2_dvd              = s8_b7_ff[31] ? s8_b7_ff : (s8_b7_ff << 1);
   end

   logic                 d2_vld;
   logic [31:0]          d2_quo;
   bsc_pkg::d2_side_type d2_side;

   bsc_div_pipe #(
      .SIDE_W ($bits(bsc_pkg::d2_side_type))
   ) u_div_pres (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s8_vld_ff),
      .in_dvd   (d2_dvd),
      .in_dvs   (s8_b4_ff),
      .in_side  (d2_in_side),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // ---------------------------------------------------------------------
   // S10: P, (P>>8)^2, -7357*P
   // ---------------------------------------------------------------------
   logic             s10_vld_ff;
   bsc_pkg::ctx_type s10_ctx_ff;
   logic [31:0]      s10_p_ff, s10_phsq_ff, s10_lin_ff;

   logic [31:0] p_t, ph_t;
   assign p_t  = d2_side.post_shl ? (d2_quo << 1) : d2_quo;
   assign ph_t = bsc_pkg::asr32(p_t, 5'd8);

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (adv) begin
         s10_vld_ff <= d2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_ctx_ff  <= d2_side.ctx;
         s10_p_ff    <= p_t;
         s10_phsq_ff <= ph_t * ph_t;
         s10_lin_ff  <= bsc_pkg::K_LIN * p_t;
      end
   end

   // ---------------------------------------------------------------------
   // S11: 3038 * (P>>8)^2
   // ---------------------------------------------------------------------
   logic             s11_vld_ff;
   bsc_pkg::ctx_type s11_ctx_ff;
   logic [31:0]      s11_p_ff, s11_sqk_ff, s11_x2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else if (adv) begin
         s11_vld_ff <= s10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_ctx_ff <= s10_ctx_ff;
         s11_p_ff   <= s10_p_ff;
         s11_sqk_ff <= s10_phsq_ff * bsc_pkg::K_SQ;
         s11_x2_ff  <= bsc_pkg::asr32(s10_lin_ff, 5'd16);
      end
   end

   // ---------------------------------------------------------------------
   // Output register: final pressure sum and result select
   // ---------------------------------------------------------------------
   logic [31:0] pres_t, corr_t, val_in;
   logic [31:0] rsp_val_ff;
   logic        rsp_err_ff;

   assign corr_t = bsc_pkg::asr32(s11_sqk_ff, 5'd16) + s11_x2_ff + bsc_pkg::K_OFS;
   assign pres_t = s11_p_ff + bsc_pkg::asr32(corr_t, 5'd4);

   always_comb begin
      priority if (s11_ctx_ff.err) begin
         val_in = '0;
      end else if (s11_ctx_ff.func) begin
         val_in = pres_t;
      end else begin
         val_in = s11_ctx_ff.tval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= s11_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_val_ff <= val_in;
         rsp_err_ff <= s11_ctx_ff.err;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_value     = rsp_val_ff;
   assign rsp_div_error = rsp_err_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_value == '0)
      else $error("error result carries nonzero value");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_vld_ff) && $stable(s11_vld_ff))
      else $error("pipeline moved during stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_vld_ff)
      else $error("valid bits not cleared by reset");

endmodule
